FILE: sv/brra_pkg.sv
// Package for the bounded rational ratio approximation core.
// Holds widths, the register reset value and shared control structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package brra_pkg;
  localparam int RATE_BITS = 32;
  localparam int CNT_BITS  = 6;
  localparam logic [RATE_BITS-1:0] MAXD_RESET = RATE_BITS'(1024);

  // Request and reply between sequencer and serial units.
  typedef struct packed {
    logic start;
  } brra_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } brra_sts_t;
endpackage
`default_nettype wire

FILE: sv/brra_div.sv
// Restoring bit-serial divider: one quotient bit per cycle.
// Depends on brra_pkg.
`timescale 1ns / 1ps
`default_nettype none
module brra_div (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire brra_pkg::brra_ctl_t            ctl,
  input  wire logic [brra_pkg::RATE_BITS-1:0] dividend,
  input  wire logic [brra_pkg::RATE_BITS-1:0] divisor,
  output      brra_pkg::brra_sts_t            sts,
  output      logic [brra_pkg::RATE_BITS-1:0] quotient,
  output      logic [brra_pkg::RATE_BITS-1:0] remainder
);
  import brra_pkg::*;

  logic [RATE_BITS-1:0] q_r, q_nxt, d_r, d_nxt;
  logic [RATE_BITS:0]   rem_r, rem_nxt;
  logic [RATE_BITS:0]   trial;
  logic [CNT_BITS-1:0]  cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt, done_r, done_nxt;

  // Shift in one dividend bit and try a subtract.
  always_comb begin
    q_nxt    = q_r;
    d_nxt    = d_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r[RATE_BITS-1:0], q_r[RATE_BITS-1]} - {1'b0, d_r};
    if (ctl.start && !busy_r) begin
      q_nxt    = dividend;
      d_nxt    = divisor;
      rem_nxt  = '0;
      cnt_nxt  = CNT_BITS'(RATE_BITS);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[RATE_BITS]) begin
        rem_nxt = trial;
        q_nxt   = {q_r[RATE_BITS-2:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[RATE_BITS-1:0], q_r[RATE_BITS-1]};
        q_nxt   = {q_r[RATE_BITS-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_BITS'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    d_r   <= d_nxt;
    rem_r <= rem_nxt;
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign sts.busy  = busy_r;
  assign sts.done  = done_r;
  assign quotient  = q_r;
  assign remainder = rem_r[RATE_BITS-1:0];

  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r)) else $error("done without busy");
  a_cnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> cnt_r == '0) else $error("count nonzero while idle");
  a_busy_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> cnt_r != '0) else $error("busy with zero count");
endmodule
`default_nettype wire

FILE: sv/brra_mac.sv
// Bit-serial multiply-add: res = a * b + c, one bit of a per cycle.
// Depends on brra_pkg. Result is 2*RATE_BITS+1 wide so overflow is visible.
`timescale 1ns / 1ps
`default_nettype none
module brra_mac (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire brra_pkg::brra_ctl_t              ctl,
  input  wire logic [brra_pkg::RATE_BITS-1:0]   mul_a,
  input  wire logic [brra_pkg::RATE_BITS-1:0]   mul_b,
  input  wire logic [brra_pkg::RATE_BITS-1:0]   add_c,
  output      brra_pkg::brra_sts_t              sts,
  output      logic [2*brra_pkg::RATE_BITS:0]   result
);
  import brra_pkg::*;

  localparam int W = 2*RATE_BITS + 1;

  logic [RATE_BITS-1:0] a_r, a_nxt;
  logic [W-1:0]         b_r, b_nxt, acc_r, acc_nxt;
  logic [CNT_BITS-1:0]  cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt, done_r, done_nxt;

  // Add the shifted multiplicand for each set bit of a.
  always_comb begin
    a_nxt    = a_r;
    b_nxt    = b_r;
    acc_nxt  = acc_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (ctl.start && !busy_r) begin
      a_nxt    = mul_a;
      b_nxt    = W'(mul_b);
      acc_nxt  = W'(add_c);
      cnt_nxt  = CNT_BITS'(RATE_BITS);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (a_r[0]) acc_nxt = acc_r + b_r;
      a_nxt   = a_r >> 1;
      b_nxt   = b_r << 1;
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_BITS'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    acc_r <= acc_nxt;
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign result   = acc_r;

  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r)) else $error("done without busy");
  a_busy_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> cnt_r != '0) else $error("busy with zero count");
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r) else $error("done while busy");
endmodule
`default_nettype wire

FILE: sv/bounded_rational_ratio_approx_core.sv
// Bounded rational ratio approximation core: sequencer plus serial units.
// Depends on brra_pkg, brra_div, brra_mac.
// Sequence: each Euclid step runs one divide and two multiply-adds on the serial units,
// then gcd divides and two reduction divides follow. Throughput: one transaction at a
// time, busy high until out_valid; zero rates answer in the cycle after acceptance and
// leave busy low. Reset: synchronous rst_n clears control, limit is 1024.
`timescale 1ns / 1ps
`default_nettype none
module bounded_rational_ratio_approx_core (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  output      logic                           busy,
  input  wire logic [brra_pkg::RATE_BITS-1:0] in_target_rate,
  input  wire logic [brra_pkg::RATE_BITS-1:0] in_source_rate,
  output      logic                           out_valid,
  output      logic [brra_pkg::RATE_BITS-1:0] out_numerator,
  output      logic [brra_pkg::RATE_BITS-1:0] out_denominator,
  output      logic                           out_rate_error,
  input  wire logic                           cfg_valid,
  output      logic                           cfg_ready,
  input  wire logic [brra_pkg::RATE_BITS-1:0] cfg_den_limit
);
  import brra_pkg::*;

  localparam int W = 2*RATE_BITS + 1;
  localparam logic [3:0] S_IDLE = 4'd0, S_DIV = 4'd1, S_DIVW = 4'd2,
    S_MH = 4'd3, S_MHW = 4'd4, S_MK = 4'd5, S_MKW = 4'd6,
    S_CHK = 4'd7, S_SQD = 4'd8, S_SQDW = 4'd9, S_SH = 4'd10, S_SHW = 4'd11,
    S_SK = 4'd12, S_SKW = 4'd13, S_GCD = 4'd14, S_GCDW = 4'd15;
  // Reduction phase reuses the divide states; flag selects its purpose.
  localparam logic [1:0] RED_GCD = 2'd0, RED_NUM = 2'd1, RED_DEN = 2'd2;

  logic [3:0] st_r, st_nxt;
  logic [RATE_BITS-1:0] maxd_r;
  logic [RATE_BITS-1:0] n_r, d_r, a_r, rm_r, hp1_r, hp2_r, kp1_r, kp2_r;
  logic [RATE_BITS-1:0] mq_r, sh_r, gx_r, gy_r;
  logic [W-1:0] h_r;
  logic [RATE_BITS-1:0] out_n_r, out_d_r;
  logic out_v_r, out_e_r;
  logic [1:0] red_r;

  brra_ctl_t div_ctl, mac_ctl;
  brra_sts_t div_sts, mac_sts;
  logic [RATE_BITS-1:0] div_a, div_b, div_q, div_rm, mac_a, mac_b, mac_c;
  logic [W-1:0] mac_res;
  logic [RATE_BITS-1:0] maxd_eff;

  assign maxd_eff = (maxd_r == '0) ? RATE_BITS'(1) : maxd_r;

  brra_div u_div (.clk, .rst_n, .ctl(div_ctl), .dividend(div_a), .divisor(div_b),
    .sts(div_sts), .quotient(div_q), .remainder(div_rm));
  brra_mac u_mac (.clk, .rst_n, .ctl(mac_ctl), .mul_a(mac_a), .mul_b(mac_b),
    .add_c(mac_c), .sts(mac_sts), .result(mac_res));

  // Hold the limit register; writes come only while idle.
  assign cfg_ready = (st_r == S_IDLE) && !start;
  always_ff @(posedge clk) begin
    if (!rst_n) maxd_r <= MAXD_RESET;
    else if (cfg_valid && cfg_ready) maxd_r <= cfg_den_limit;
  end

  // Unit operand selection.
  always_comb begin
    div_ctl.start = 1'b0;
    mac_ctl.start = 1'b0;
    div_a = n_r; div_b = d_r;
    mac_a = a_r; mac_b = hp1_r; mac_c = hp2_r;
    case (st_r)
      S_DIV:  div_ctl.start = 1'b1;
      S_MH:   mac_ctl.start = 1'b1;
      S_MK:   begin mac_ctl.start = 1'b1; mac_b = kp1_r; mac_c = kp2_r; end
      S_SQD:  begin div_ctl.start = 1'b1; div_a = maxd_eff - kp2_r; div_b = kp1_r; end
      S_SH:   begin mac_ctl.start = 1'b1; mac_a = mq_r; end
      S_SK:   begin mac_ctl.start = 1'b1; mac_a = mq_r; mac_b = kp1_r; mac_c = kp2_r; end
      S_GCD:  begin
        // Skip the divide once the gcd remainder reaches zero.
        div_ctl.start = !(red_r == RED_GCD && gy_r == '0);
        if (red_r == RED_GCD) begin div_a = gx_r; div_b = gy_r; end
        else if (red_r == RED_NUM) begin div_a = hp1_r; div_b = gx_r; end
        else begin div_a = kp1_r; div_b = gx_r; end
      end
      default: ;
    endcase
  end

  // Sequencer.
  always_comb st_nxt = st_r;

  // Pulse the result strobe for one cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) out_v_r <= 1'b0;
    else out_v_r <= (st_r == S_IDLE && start &&
                     (in_target_rate == '0 || in_source_rate == '0)) ||
                    (st_r == S_GCDW && div_sts.done && red_r == RED_DEN);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= S_IDLE;
      red_r   <= RED_GCD;
    end else begin
      case (st_r)
        S_IDLE: if (start) begin
          out_e_r <= (in_target_rate == '0 || in_source_rate == '0);
          if (in_target_rate == '0 || in_source_rate == '0) begin
            out_n_r <= '0; out_d_r <= '0;
          end else begin
            n_r <= in_target_rate; d_r <= in_source_rate;
            hp2_r <= '0; kp2_r <= RATE_BITS'(1);
            hp1_r <= RATE_BITS'(1); kp1_r <= '0;
            st_r <= S_DIV;
          end
        end
        S_DIV:  st_r <= S_DIVW;
        S_DIVW: if (div_sts.done) begin
          a_r <= div_q; rm_r <= div_rm; st_r <= S_MH;
        end
        S_MH:   st_r <= S_MHW;
        S_MHW:  if (mac_sts.done) begin h_r <= mac_res; st_r <= S_MK; end
        S_MK:   st_r <= S_MKW;
        S_MKW:  if (mac_sts.done) begin
          // Stop on overflow, go semiconvergent on limit, else advance.
          if (h_r[W-1:RATE_BITS] != '0 || mac_res[W-1:RATE_BITS] != '0) begin
            st_r <= S_CHK;
          end else if (mac_res[RATE_BITS-1:0] > maxd_eff) begin
            if (a_r != '0 && kp1_r != '0 && kp2_r <= maxd_eff) st_r <= S_SQD;
            else st_r <= S_CHK;
          end else begin
            hp2_r <= hp1_r; kp2_r <= kp1_r;
            hp1_r <= h_r[RATE_BITS-1:0]; kp1_r <= mac_res[RATE_BITS-1:0];
            if (rm_r == '0) st_r <= S_CHK;
            else begin n_r <= d_r; d_r <= rm_r; st_r <= S_DIV; end
          end
        end
        S_SQD:  st_r <= S_SQDW;
        S_SQDW: if (div_sts.done) begin
          mq_r <= div_q;
          st_r <= (div_q == '0) ? S_CHK : S_SH;
        end
        S_SH:   st_r <= S_SHW;
        S_SHW:  if (mac_sts.done) begin sh_r <= mac_res[RATE_BITS-1:0];
          h_r <= mac_res; st_r <= S_SK; end
        S_SK:   st_r <= S_SKW;
        S_SKW:  if (mac_sts.done) begin
          if (h_r[W-1:RATE_BITS] == '0 && mac_res[W-1:RATE_BITS] == '0 &&
              mac_res[RATE_BITS-1:0] <= maxd_eff && mac_res[RATE_BITS-1:0] != '0) begin
            hp1_r <= sh_r; kp1_r <= mac_res[RATE_BITS-1:0];
          end
          st_r <= S_CHK;
        end
        S_CHK: begin
          // Zero numerator falls back to 1/limit; then start gcd.
          if (hp1_r == '0) begin
            hp1_r <= RATE_BITS'(1); kp1_r <= maxd_eff;
            gx_r <= RATE_BITS'(1); gy_r <= maxd_eff;
          end else begin
            gx_r <= hp1_r; gy_r <= kp1_r;
          end
          red_r <= RED_GCD;
          st_r  <= S_GCD;
        end
        S_GCD: begin
          if (red_r == RED_GCD && gy_r == '0) begin
            if (gx_r == '0) gx_r <= RATE_BITS'(1);
            red_r <= RED_NUM;
          end else st_r <= S_GCDW;
        end
        S_GCDW: if (div_sts.done) begin
          if (red_r == RED_GCD) begin
            gx_r <= gy_r; gy_r <= div_rm; st_r <= S_GCD;
          end else if (red_r == RED_NUM) begin
            out_n_r <= div_q; red_r <= RED_DEN; st_r <= S_GCD;
          end else begin
            out_d_r <= div_q; st_r <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign busy            = (st_r != S_IDLE) || (st_nxt != st_r);
  assign out_valid       = out_v_r;
  assign out_numerator   = out_n_r;
  assign out_denominator = out_d_r;
  assign out_rate_error  = out_e_r;

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_e_r |-> out_n_r == '0 && out_d_r == '0) else $error("error payload");
  a_den_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !out_e_r |-> out_d_r <= maxd_eff && out_d_r != '0) else $error("den limit");
  a_units_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(div_sts.busy && mac_sts.busy)) else $error("units overlap");
  a_idle_cfg: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ready |-> !div_sts.busy && !mac_sts.busy) else $error("cfg while busy");
endmodule
`default_nettype wire

FILE: test/brra_ratio_checker.sv
// Checker for the bounded rational ratio approximation core.
// Watches the command, result and register channels, predicts each fraction
// and compares it. Depends on brra_pkg.
`timescale 1ns / 1ps
module brra_ratio_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic                           busy,
  input  logic [brra_pkg::RATE_BITS-1:0] in_target_rate,
  input  logic [brra_pkg::RATE_BITS-1:0] in_source_rate,
  input  logic                           out_valid,
  input  logic [brra_pkg::RATE_BITS-1:0] out_numerator,
  input  logic [brra_pkg::RATE_BITS-1:0] out_denominator,
  input  logic                           out_rate_error,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [brra_pkg::RATE_BITS-1:0] cfg_den_limit,
  output int                             fail_count,
  output int                             fractions_pending
);
  import brra_pkg::*;

  typedef struct {
    logic [RATE_BITS-1:0] num;
    logic [RATE_BITS-1:0] den;
    logic                 err;
  } fraction_t;

  fraction_t            fraction_q[$];
  logic [RATE_BITS-1:0] den_limit;

  // Best rational approximation by continued fraction, in 64-bit arithmetic
  function automatic fraction_t approx_ratio(logic [RATE_BITS-1:0] tgt,
                                             logic [RATE_BITS-1:0] src,
                                             logic [RATE_BITS-1:0] limit);
    fraction_t      f;
    logic [63:0]    top_val, n, d, maxd, q, r, h, k, mq, sh, sk, t, x, y;
    logic [63:0]    h2, k2, h1, k1;
    top_val = (64'd1 << RATE_BITS) - 64'd1;
    n = 64'(tgt);
    d = 64'(src);
    maxd = (limit == '0) ? 64'd1 : 64'(limit);
    h2 = 64'd0; k2 = 64'd1; h1 = 64'd1; k1 = 64'd0;
    if (n == 0 || d == 0) begin
      f.num = '0; f.den = '0; f.err = 1'b1;
      return f;
    end
    forever begin
      q = n / d;
      r = n % d;
      h = q * h1 + h2;
      k = q * k1 + k2;
      if (h > top_val || k > top_val) break;
      // Denominator over the limit: try the largest semiconvergent
      if (k > maxd) begin
        if (q > 0 && k1 > 0 && k2 <= maxd) begin
          mq = (maxd - k2) / k1;
          if (mq > 0) begin
            sh = mq * h1 + h2;
            sk = mq * k1 + k2;
            if (sh <= top_val && sk <= maxd && sk > 0) begin
              h1 = sh;
              k1 = sk;
            end
          end
        end
        break;
      end
      h2 = h1; k2 = k1; h1 = h; k1 = k;
      if (r == 0) break;
      n = d;
      d = r;
    end
    if (h1 == 0) begin
      h1 = 64'd1;
      k1 = maxd;
    end
    // Reduce by the gcd
    x = h1;
    y = k1;
    while (y != 0) begin
      t = y;
      y = x % y;
      x = t;
    end
    if (x == 0) x = 64'd1;
    f.num = RATE_BITS'(h1 / x);
    f.den = RATE_BITS'(k1 / x);
    f.err = 1'b0;
    return f;
  endfunction

  assign fractions_pending = fraction_q.size();

  // Track the register, queue predictions, compare results
  always @(posedge clk) begin
    fraction_t want;
    if (!rst_n) begin
      den_limit <= MAXD_RESET;
      fraction_q.delete();
      fail_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) den_limit <= cfg_den_limit;
      if (start && !busy)
        fraction_q.push_back(approx_ratio(in_target_rate, in_source_rate, den_limit));
      if (out_valid) begin
        if (fraction_q.size() == 0) begin
          $error("unexpected result: num %0d den %0d err %0b",
                 out_numerator, out_denominator, out_rate_error);
          fail_count++;
        end else begin
          want = fraction_q.pop_front();
          if (out_numerator !== want.num) begin
            $error("numerator: expected %0d, actual %0d", want.num, out_numerator);
            fail_count++;
          end
          if (out_denominator !== want.den) begin
            $error("denominator: expected %0d, actual %0d", want.den, out_denominator);
            fail_count++;
          end
          if (out_rate_error !== want.err) begin
            $error("rate_error: expected %0b, actual %0b", want.err, out_rate_error);
            fail_count++;
          end
        end
      end
    end
  end
endmodule

FILE: test/bounded_rational_ratio_approx_core_test.sv
// Top of the ratio approximation testbench: clock, reset, stimulus, verdict.
// Depends on brra_pkg, bounded_rational_ratio_approx_core, brra_ratio_checker.
`timescale 1ns / 1ps
module bounded_rational_ratio_approx_core_test;
  import brra_pkg::*;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic [RATE_BITS-1:0] in_target_rate = '0;
  logic [RATE_BITS-1:0] in_source_rate = '0;
  logic                 out_valid;
  logic [RATE_BITS-1:0] out_numerator;
  logic [RATE_BITS-1:0] out_denominator;
  logic                 out_rate_error;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [RATE_BITS-1:0] cfg_den_limit = '0;
  int                   fail_count;
  int                   fractions_pending;
  int                   ratio_count;

  localparam logic [RATE_BITS-1:0] ALL_ONES = '1;

  always #10 clk = ~clk;

  bounded_rational_ratio_approx_core DUT (.*);
  brra_ratio_checker checker_i (.*);

  // Drop start and wait until every predicted fraction has arrived
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (fractions_pending != 0 || busy) @(posedge clk);
  endtask

  // Write the denominator limit while the core is idle
  task automatic set_limit(logic [RATE_BITS-1:0] limit);
    drain();
    cfg_valid     <= 1'b1;
    cfg_den_limit <= limit;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid     <= 1'b0;
    cfg_den_limit <= $urandom;
  endtask

  // Issue one transaction; start stays high until the caller idles
  task automatic send_ratio(logic [RATE_BITS-1:0] tgt, logic [RATE_BITS-1:0] src,
                            bit may_idle);
    if (may_idle && $urandom_range(99) < 6) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 40)) @(posedge clk);
    end
    start          <= 1'b1;
    in_target_rate <= tgt;
    in_source_rate <= src;
    do @(posedge clk); while (busy);
    ratio_count++;
  endtask

  // Mix of realistic audio rates, small and raw random rates, and zero rates
  function automatic logic [RATE_BITS-1:0] pick_rate();
    int unsigned rates[8] = '{8000, 11025, 16000, 22050, 44100, 48000, 96000, 192000};
    case ($urandom_range(9))
      0:       return '0;
      1, 2, 3: return RATE_BITS'(rates[$urandom_range(7)]);
      4, 5:    return RATE_BITS'($urandom_range(1, 100000));
      default: return RATE_BITS'($urandom);
    endcase
  endfunction

  task automatic random_burst(int n);
    for (int i = 0; i < n; i++)
      send_ratio(pick_rate(), pick_rate(), !(ratio_count >= 120 && ratio_count < 180));
  endtask

  initial begin
    ratio_count = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: zero rates, extremes and exact ratios at the reset limit
    send_ratio(0, 48000, 0);
    send_ratio(44100, 0, 0);
    send_ratio(0, 0, 0);
    send_ratio(ALL_ONES, ALL_ONES, 0);
    send_ratio(ALL_ONES, 1, 0);
    send_ratio(1, ALL_ONES, 0);
    send_ratio(1, 1, 0);
    send_ratio(48000, 44100, 0);
    send_ratio(44100, 48000, 0);
    send_ratio(32'hAAAA_AAAA, 32'h5555_5555, 0);
    send_ratio(1, 1000000, 0);
    send_ratio(1000000, 3, 0);
    // Zero limit behaves as one; tiny ratios fall back to one over the limit
    set_limit(0);
    send_ratio(1, 1000000, 0);
    send_ratio(48000, 44100, 0);
    send_ratio(3, 7, 0);
    set_limit(1);
    send_ratio(1, ALL_ONES, 0);
    send_ratio(7, 3, 0);
    set_limit(ALL_ONES);
    send_ratio(ALL_ONES, ALL_ONES - 1, 0);
    send_ratio(32'h9E37_79B9, 32'h6A09_E667, 0);
    send_ratio(1, ALL_ONES, 0);

    // Random phases over several limits
    set_limit(MAXD_RESET);
    random_burst(60);
    drain();
    random_burst(40);
    set_limit($urandom_range(1, 64));
    random_burst(60);
    set_limit(ALL_ONES);
    random_burst(50);
    set_limit($urandom);
    random_burst(50);
    set_limit(1);
    random_burst(20);
    set_limit(0);
    random_burst(20);

    drain();
    repeat (100) @(posedge clk);
    if (fail_count == 0 && fractions_pending == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    #400ms;
    $display("[FAIL] regression broken");
    $finish;
  end
endmodule

FILE: files.f
sv/brra_pkg.sv
sv/brra_div.sv
sv/brra_mac.sv
sv/bounded_rational_ratio_approx_core.sv
test/brra_ratio_checker.sv
test/bounded_rational_ratio_approx_core_test.sv
